[rtl/threshold_promote_cache_list_core_defines.svh]
// Assertion macros shared by the checker of the threshold promote cache list.
// No dependencies; included by the files that assert.
`ifndef THRESHOLD_PROMOTE_CACHE_LIST_CORE_DEFINES_SVH
`define THRESHOLD_PROMOTE_CACHE_LIST_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tpc_pkg.sv]
// Shared types and constants of the threshold promote cache list.
// No dependencies; used by the interfaces, controller, datapath, top level and checker.
package tpc_pkg;

   // Parameter defaults
   localparam int DEPTH_DEF    = 16;
   localparam int TAG_BITS_DEF = 32;

   // Fixed field widths
   localparam int COUNT_W    = 16;
   localparam int THRESH_W   = 16;
   localparam int CAP_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd2;
   localparam logic [CAP_W-1:0]    CAP_RESET    = 5'd16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY  = 1'b1;

   // Request kinds
   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // latch the incoming item
      logic compare;  // register the tag match vector
      logic commit;   // update the list and load the result register
   } tpc_cmd_type;

endpackage

[rtl/tpc_if.sv]
// Request and response channel interfaces of the threshold promote cache list.
// Depends on tpc_pkg for field widths.
interface tpc_req_if
   import tpc_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [TAG_BITS-1:0] tag;

   modport source (output valid, kind, tag, input ready);
   modport sink   (input valid, kind, tag, output ready);
endinterface

interface tpc_rsp_if
   import tpc_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF,
   parameter int OCC_W    = $clog2(DEPTH_DEF + 1)
) ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [COUNT_W-1:0]  hit_count;
   logic                promoted;
   logic                evicted;
   logic [TAG_BITS-1:0] evicted_tag;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, hit, hit_count, promoted, evicted, evicted_tag, occupancy,
                   input ready);
   modport sink   (input valid, hit, hit_count, promoted, evicted, evicted_tag, occupancy,
                   output ready);
endinterface

[rtl/tpc_ctrl.sv]
// Controller of the threshold promote cache list: sequences load, compare and commit.
// Depends on tpc_pkg for the command struct.
module tpc_ctrl
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tpc_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CMP  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       commit;
   logic       load;

   // Commit once the result register is free or being emptied
   assign commit    = (state_ff == ST_UPD) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || commit;
   assign load      = req_valid && req_ready;

   assign cmd.load    = load;
   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.commit  = commit;
   assign rsp_valid   = rsp_valid_ff;

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (load) state_in = ST_CMP;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD: begin
            if (commit) state_in = load ? ST_CMP : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tpc_dp.sv]
// Datapath of the threshold promote cache list: entry cells, match vector,
// configuration registers and result register. Depends on tpc_pkg.
module tpc_dp
   import tpc_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF,
   parameter int OCC_W    = $clog2(DEPTH_DEF + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tpc_cmd_type           cmd,
   input  logic                  req_kind,
   input  logic [TAG_BITS-1:0]   req_tag,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_hit,
   output logic [COUNT_W-1:0]    rsp_hit_count,
   output logic                  rsp_promoted,
   output logic                  rsp_evicted,
   output logic [TAG_BITS-1:0]   rsp_evicted_tag,
   output logic [OCC_W-1:0]      rsp_occupancy
);

   // Configuration
   logic [THRESH_W-1:0] threshold_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [OCC_W-1:0]    eff_cap;

   // Latched item and match vector
   logic                kind_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [DEPTH-1:0]    match_ff, match_in;

   // Entry cells
   logic [TAG_BITS-1:0] tag_arr_ff   [DEPTH];
   logic [TAG_BITS-1:0] tag_arr_in   [DEPTH];
   logic [COUNT_W-1:0]  count_arr_ff [DEPTH];
   logic [COUNT_W-1:0]  count_arr_in [DEPTH];
   logic [OCC_W-1:0]    used_ff, used_in;

   // Update terms
   logic [DEPTH-1:0]    hitv, below, shift_mask, bump_mask;
   logic                hit, promote, evict, flush, upd_entries, front_write;
   logic [COUNT_W-1:0]  old_count, new_count, front_count;
   logic [TAG_BITS-1:0] ev_tag;

   // Result register
   logic                hit_ff, promoted_ff, evicted_ff;
   logic [COUNT_W-1:0]  hit_count_ff;
   logic [TAG_BITS-1:0] evicted_tag_ff;
   logic [OCC_W-1:0]    occupancy_ff;

   // Clamp capacity into one to DEPTH
   always_comb begin
      if (int'(capacity_ff) > DEPTH)  eff_cap = OCC_W'(DEPTH);
      else if (capacity_ff == '0)     eff_cap = OCC_W'(1);
      else                            eff_cap = OCC_W'(capacity_ff);
   end

   // Compare the tag against every valid entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (tag_arr_ff[i] == tag_ff) && (OCC_W'(i) < used_ff);
      end
   end

   // Isolate the first match and gather its count and the tail tag
   assign flush = (kind_ff == KIND_FLUSH);
   assign hitv  = match_ff & (~match_ff + DEPTH'(1));
   assign hit   = |hitv;
   assign below = hitv - DEPTH'(1);

   always_comb begin
      old_count = '0;
      ev_tag    = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hitv[i]) old_count = old_count | count_arr_ff[i];
         if (OCC_W'(i) == used_ff - OCC_W'(1)) ev_tag = ev_tag | tag_arr_ff[i];
      end
   end

   assign new_count = (old_count == COUNT_MAX) ? old_count : old_count + COUNT_W'(1);
   assign promote   = hit && !hitv[0] && (old_count == threshold_ff) && (old_count != COUNT_MAX);
   assign evict     = !hit && (used_ff >= eff_cap);

   // Next occupancy
   always_comb begin
      priority if (flush) used_in = '0;
      else if (hit)       used_in = used_ff;
      else if (evict)     used_in = used_ff;
      else                used_in = used_ff + OCC_W'(1);
   end

   // Decide which cells shift toward the tail and which take the new count
   assign upd_entries = cmd.commit && !flush;
   always_comb begin
      front_write = 1'b0;
      front_count = new_count;
      shift_mask  = '0;
      bump_mask   = '0;
      if (!hit) begin
         front_write = 1'b1;
         front_count = COUNT_W'(1);
         for (int i = 1; i < DEPTH; i++) shift_mask[i] = (OCC_W'(i) < used_in);
      end else if (promote) begin
         front_write = 1'b1;
         shift_mask  = (below | hitv) & ~DEPTH'(1);
      end else begin
         bump_mask = hitv;
      end
   end

   // Entry cells: each takes its neighbor toward the front, or a new count
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_front
         always_comb begin
            tag_arr_in[g]   = tag_arr_ff[g];
            count_arr_in[g] = count_arr_ff[g];
            if (upd_entries && front_write) begin
               tag_arr_in[g]   = tag_ff;
               count_arr_in[g] = front_count;
            end else if (upd_entries && bump_mask[g]) begin
               count_arr_in[g] = new_count;
            end
         end
      end else begin : g_rest
         always_comb begin
            tag_arr_in[g]   = tag_arr_ff[g];
            count_arr_in[g] = count_arr_ff[g];
            if (upd_entries && shift_mask[g]) begin
               tag_arr_in[g]   = tag_arr_ff[g-1];
               count_arr_in[g] = count_arr_ff[g-1];
            end else if (upd_entries && bump_mask[g]) begin
               count_arr_in[g] = new_count;
            end
         end
      end

      always_ff @(posedge clock) begin
         tag_arr_ff[g]   <= tag_arr_in[g];
         count_arr_ff[g] <= count_arr_in[g];
      end
   end

   // Control state: configuration and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         capacity_ff  <= CAP_RESET;
         used_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_THRESHOLD: threshold_ff <= csr_wdata[THRESH_W-1:0];
               REG_CAPACITY:  capacity_ff  <= csr_wdata[CAP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) used_ff <= used_in;
      end
   end

   // Payload: latched item, match vector and result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         tag_ff  <= req_tag;
      end
      if (cmd.compare) match_ff <= match_in;
      if (cmd.commit) begin
         hit_ff         <= !flush && hit;
         hit_count_ff   <= flush ? '0 : (hit ? new_count : COUNT_W'(1));
         promoted_ff    <= !flush && promote;
         evicted_ff     <= !flush && evict;
         evicted_tag_ff <= (!flush && evict) ? ev_tag : '0;
         occupancy_ff   <= used_in;
      end
   end

   assign rsp_hit         = hit_ff;
   assign rsp_hit_count   = hit_count_ff;
   assign rsp_promoted    = promoted_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_tag = evicted_tag_ff;
   assign rsp_occupancy   = occupancy_ff;

endmodule

[rtl/threshold_promote_cache_list_core.sv]
// Top level of the threshold promote cache list: controller plus datapath.
// Depends on tpc_pkg, tpc_if, tpc_ctrl and tpc_dp.
//
// Usage:
//   req_ch carries one item: kind (access or flush) and tag. rsp_ch returns
//   exactly one result per item: hit, hit_count, promoted, evicted,
//   evicted_tag and occupancy. Items move on valid and ready both high.
//   csr_wr_en writes csr_wdata into register csr_index (0 threshold,
//   1 capacity); write only while no item is in flight.
//   An accepted item passes the compare step (tags of all entries against
//   the item) and then the list update step, where it commits and loads
//   the result register. The next item is taken in the same cycle the
//   previous one commits, so only one item is in flight at a time.
//   Reset empties the list, sets threshold to 2 and capacity to 16.
//   When rsp_ch stalls, the result is held in the output register; the
//   next item finishes its compare and then waits at the update step,
//   and req_ch stays not ready until that result can be written.
module threshold_promote_cache_list_core
   import tpc_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tpc_req_if.sink               req_ch,
   tpc_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int OCC_W = $clog2(DEPTH + 1);

   tpc_cmd_type cmd;

   tpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tpc_dp #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS),
      .OCC_W    (OCC_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_ch.kind),
      .req_tag         (req_ch.tag),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_hit         (rsp_ch.hit),
      .rsp_hit_count   (rsp_ch.hit_count),
      .rsp_promoted    (rsp_ch.promoted),
      .rsp_evicted     (rsp_ch.evicted),
      .rsp_evicted_tag (rsp_ch.evicted_tag),
      .rsp_occupancy   (rsp_ch.occupancy)
   );

endmodule

[rtl/tpc_checker.sv]
// Port-level checks of the threshold promote cache list, bound to the top level.
// Depends on tpc_pkg and threshold_promote_cache_list_core_defines.svh.
`include "threshold_promote_cache_list_core_defines.svh"

module tpc_checker
   import tpc_pkg::*;
#(
   parameter int OCC_W = $clog2(DEPTH_DEF + 1)
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic [COUNT_W-1:0] rsp_hit_count,
   input logic               rsp_promoted,
   input logic               rsp_evicted,
   input logic [OCC_W-1:0]   rsp_occupancy
);

   // A stalled result stays offered
   `TPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // One item at a time: no accept right after an accept
   `TPC_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "item accepted while busy")

   // A miss inserts with count one and leaves the list non-empty
   `TPC_ASSERT_SAME(a_miss_count, clock, reset, rsp_valid && !rsp_hit && (rsp_occupancy != '0), rsp_hit_count == COUNT_W'(1), "miss count is not one")

   // Promotion only on a hit
   `TPC_ASSERT_SAME(a_promote_hit, clock, reset, rsp_valid && rsp_promoted, rsp_hit, "promotion without hit")

   // Eviction only on a miss that leaves entries
   `TPC_ASSERT_SAME(a_evict_miss, clock, reset, rsp_valid && rsp_evicted, !rsp_hit && (rsp_occupancy != '0), "eviction on hit or flush")

endmodule

bind threshold_promote_cache_list_core tpc_checker #(.OCC_W(OCC_W)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_hit       (rsp_ch.hit),
   .rsp_hit_count (rsp_ch.hit_count),
   .rsp_promoted  (rsp_ch.promoted),
   .rsp_evicted   (rsp_ch.evicted),
   .rsp_occupancy (rsp_ch.occupancy)
);
